// ===== rtl/crypt_base64_decoder_core_macros.svh =====
// Assertion macros used by the checker of the decoder.
`ifndef CRYPT_BASE64_DECODER_CORE_MACROS_SVH
`define CRYPT_BASE64_DECODER_CORE_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define CB64D_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("cb64d assertion failed");

// Implication checked at every clock edge outside reset.
`define CB64D_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cb64d assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define CB64D_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cb64d assertion failed");

`endif

// ===== rtl/cb64d_pkg.sv =====
package cb64d_pkg;

  localparam int MAX_BYTES = 64;

  localparam int CHAR_W  = 8;
  localparam int CNT_W   = 7;
  localparam int STAT_W  = 2;
  localparam int ACC_W   = 24;

  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

  localparam logic [CHAR_W-1:0] CHR_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CHR_DOLLAR = 8'h24;
  localparam logic [CHAR_W-1:0] CHR_DOT    = 8'h2E;
  localparam logic [CHAR_W-1:0] CHR_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CHR_0      = 8'h30;
  localparam logic [CHAR_W-1:0] CHR_9      = 8'h39;
  localparam logic [CHAR_W-1:0] CHR_UA     = 8'h41;
  localparam logic [CHAR_W-1:0] CHR_UZ     = 8'h5A;
  localparam logic [CHAR_W-1:0] CHR_LA     = 8'h61;
  localparam logic [CHAR_W-1:0] CHR_LZ     = 8'h7A;

  localparam logic [STAT_W-1:0] ST_NUL     = 2'd0;
  localparam logic [STAT_W-1:0] ST_DOLLAR  = 2'd1;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;
  localparam logic [STAT_W-1:0] ST_OVF     = 2'd3;

  // Results caused by one character: up to three data bytes, then an
  // optional status beat.
  typedef struct packed {
    logic [ACC_W-1:0]  val;
    logic [1:0]        nbytes;
    logic              has_stat;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  count;
  } bundle_t;

  // Bit 6 set marks a character outside the alphabet.
  function automatic logic [6:0] char_value(input logic [CHAR_W-1:0] c);
    logic [6:0] res;
    res = 7'd64;
    if (c == CHR_DOT) begin
      res = 7'd0;
    end else if (c == CHR_SLASH) begin
      res = 7'd1;
    end else if (c >= CHR_0 && c <= CHR_9) begin
      res = 7'(c - CHR_0) + 7'd2;
    end else if (c >= CHR_UA && c <= CHR_UZ) begin
      res = 7'(c - CHR_UA) + 7'd12;
    end else if (c >= CHR_LA && c <= CHR_LZ) begin
      res = 7'(c - CHR_LA) + 7'd38;
    end
    return res;
  endfunction

endpackage

// ===== rtl/crypt_base64_decoder_core.sv =====
// A character is registered in the decode stage, and its results in the serial stage that presents them.
// Throughput: one character per cycle while out_tready is high, but a character that yields
// several result beats (at most four) holds off the next character with results until its last beat is taken.
// Reset (rst_n low, synchronous) empties both stages, clears the group and byte count
// and sets the capacity register to 64.
module crypt_base64_decoder_core
  import cb64d_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] in_char
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [23:0]      out_tdata,  // [7:0] out_byte, [9:8] status, [16:10] byte_count
  output logic             out_tuser,  // [0] item_kind
  output logic             out_tlast,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  bundle_t           bundle;
  logic              bundle_valid, bundle_ready;
  logic [7:0]        out_byte;
  logic [STAT_W-1:0] out_status;
  logic [CNT_W-1:0]  out_count;

  assign cfg_ready = 1'b1;

  cb64d_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_char      (in_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .bundle_ready (bundle_ready),
    .bundle_valid (bundle_valid),
    .bundle       (bundle)
  );

  cb64d_serial u_serial (
    .clk          (clk),
    .rst_n        (rst_n),
    .bundle_valid (bundle_valid),
    .bundle       (bundle),
    .bundle_ready (bundle_ready),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_byte     (out_byte),
    .out_kind     (out_tuser),
    .out_status   (out_status),
    .out_count    (out_count),
    .out_last     (out_tlast)
  );

  assign out_tdata = {7'd0, out_count, out_status, out_byte};

endmodule

// ===== rtl/cb64d_decode.sv =====
module cb64d_decode
  import cb64d_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [CHAR_W-1:0] in_char,
  input  logic              cfg_valid,
  input  logic [CNT_W-1:0]  cfg_data,
  input  logic              bundle_ready,
  output logic              bundle_valid,
  output bundle_t           bundle
);

  logic [CHAR_W-1:0] char_r;
  logic              char_vld_r;
  logic [CNT_W-1:0]  cap_r;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [1:0]        grp_r, grp_nxt;
  logic [CNT_W-1:0]  bytes_r, bytes_nxt;

  logic [6:0]        cval;
  logic [5:0]        v;
  logic              valid_chr, is_term, full, flushing, ovf, drop, fire;
  logic [ACC_W-1:0]  flush_val, v_sh;
  logic [7:0]        last_val;
  logic [1:0]        k, room, nbytes;
  logic [CNT_W-1:0]  lim, room_full;
  logic              has_stat;
  logic [STAT_W-1:0] status;

  always_comb begin
    cval      = char_value(char_r);
    v         = cval[5:0];
    valid_chr = !cval[6];
    is_term   = (char_r == CHR_NUL) || (char_r == CHR_DOLLAR);
    full      = valid_chr && (grp_r == 2'd3);
    flushing  = is_term || !valid_chr || full;

    case (grp_r)
      2'd0:    v_sh = {18'd0, v};
      2'd1:    v_sh = {12'd0, v, 6'd0};
      2'd2:    v_sh = {6'd0, v, 12'd0};
      default: v_sh = {v, 18'd0};
    endcase

    flush_val = full ? (acc_r | v_sh) : acc_r;
    k         = full ? 2'd3 : grp_r;

    lim       = (cap_r < CNT_W'(MAX_BYTES)) ? cap_r : CNT_W'(MAX_BYTES);
    room_full = (bytes_r >= lim) ? '0 : lim - bytes_r;
    room      = (room_full > 7'd3) ? 2'd3 : room_full[1:0];
    ovf       = room < k;

    case (k)
      2'd1:    last_val = flush_val[7:0];
      2'd2:    last_val = flush_val[15:8];
      default: last_val = flush_val[23:16];
    endcase
    drop = is_term && (k != 2'd0) && (last_val == 8'd0);

    if (!flushing) begin
      nbytes = 2'd0;
    end else if (ovf) begin
      nbytes = room;
    end else begin
      nbytes = k - {1'b0, drop};
    end

    has_stat = is_term || !valid_chr || (full && ovf);
    if (ovf) begin
      status = ST_OVF;
    end else if (is_term) begin
      status = (char_r == CHR_NUL) ? ST_NUL : ST_DOLLAR;
    end else begin
      status = ST_INVALID;
    end

    bundle.val      = flush_val;
    bundle.nbytes   = nbytes;
    bundle.has_stat = has_stat;
    bundle.status   = status;
    bundle.count    = bytes_r + CNT_W'(nbytes);

    bundle_valid = char_vld_r && (has_stat || nbytes != 2'd0) && bundle_ready;
    fire         = char_vld_r && (bundle_ready || (!has_stat && nbytes == 2'd0));
    in_tready    = !char_vld_r || fire;

    if (has_stat) begin
      acc_nxt   = '0;
      grp_nxt   = 2'd0;
      bytes_nxt = '0;
    end else if (full) begin
      acc_nxt   = '0;
      grp_nxt   = 2'd0;
      bytes_nxt = bytes_r + 7'd3;
    end else begin
      acc_nxt   = acc_r | v_sh;
      grp_nxt   = grp_r + 2'd1;
      bytes_nxt = bytes_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_vld_r <= 1'b0;
      cap_r      <= CAP_RESET;
      acc_r      <= '0;
      grp_r      <= 2'd0;
      bytes_r    <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        char_vld_r <= 1'b1;
      end else if (fire) begin
        char_vld_r <= 1'b0;
      end
      if (cfg_valid) begin
        cap_r <= cfg_data;
      end
      if (fire) begin
        acc_r   <= acc_nxt;
        grp_r   <= grp_nxt;
        bytes_r <= bytes_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      char_r <= in_char;
    end
  end

endmodule

// ===== rtl/cb64d_serial.sv =====
module cb64d_serial
  import cb64d_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              bundle_valid,
  input  bundle_t           bundle,
  output logic              bundle_ready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_byte,
  output logic              out_kind,
  output logic [STAT_W-1:0] out_status,
  output logic [CNT_W-1:0]  out_count,
  output logic              out_last
);

  bundle_t    bundle_r;
  logic       busy_r;
  logic [1:0] idx_r;
  logic       is_data, done;
  logic [2:0] total;

  always_comb begin
    total   = {1'b0, bundle_r.nbytes} + {2'b0, bundle_r.has_stat};
    is_data = idx_r < bundle_r.nbytes;
    out_last = ({1'b0, idx_r} == total - 3'd1);
    out_tvalid = busy_r;
    done = busy_r && out_tready && out_last;
    bundle_ready = !busy_r || done;

    case (idx_r)
      2'd0:    out_byte = bundle_r.val[7:0];
      2'd1:    out_byte = bundle_r.val[15:8];
      default: out_byte = bundle_r.val[23:16];
    endcase
    if (!is_data) begin
      out_byte = 8'd0;
    end
    out_kind   = !is_data;
    out_status = is_data ? '0 : bundle_r.status;
    out_count  = is_data ? '0 : bundle_r.count;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else begin
      if (bundle_valid) begin
        busy_r <= 1'b1;
        idx_r  <= 2'd0;
      end else if (done) begin
        busy_r <= 1'b0;
        idx_r  <= 2'd0;
      end else if (busy_r && out_tready) begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bundle_valid) begin
      bundle_r <= bundle;
    end
  end

endmodule

// ===== rtl/cb64d_checker.sv =====
`include "crypt_base64_decoder_core_macros.svh"

module cb64d_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  `CB64D_ASSERT_NEXT(a_hold_valid, out_tvalid && !out_tready, out_tvalid)
  `CB64D_ASSERT_IMPLY(a_status_last, out_tvalid && out_tuser, out_tlast)
  `CB64D_ASSERT_IMPLY(a_data_clean, out_tvalid && !out_tuser, out_tdata[23:8] == 16'd0)
  `CB64D_ASSERT_IMPLY(a_status_clean, out_tvalid && out_tuser, out_tdata[7:0] == 8'd0)
  `CB64D_ASSERT_ALWAYS(a_count_range, !(out_tvalid && out_tuser) || out_tdata[16:10] <= 7'd64)

endmodule

bind crypt_base64_decoder_core cb64d_checker u_cb64d_checker (.*);
